@@ design/spa_pkg.sv @@
// Shared constants, codes and the term record for the sparse polynomial accumulator.
// No dependencies; every other design file uses this package.
`default_nettype none
package spa_pkg;

   localparam int MAX_TERMS = 32;
   localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);

   localparam int COEF_W = 32;
   localparam int EXPO_W = 16;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [COEF_W-1:0] coef;
      logic [EXPO_W-1:0] expo;
   } term_type;

   // Saturating Q16.16 add.
   function automatic logic [COEF_W-1:0] sat_add(input logic [COEF_W-1:0] a,
                                                 input logic [COEF_W-1:0] b);
      logic [COEF_W:0] sum;
      sum = {a[COEF_W-1], a} + {b[COEF_W-1], b};
      if (sum[COEF_W] != sum[COEF_W-1]) begin
         sat_add = sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
      end else begin
         sat_add = sum[COEF_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

@@ design/spa_channels.sv @@
// Request and response channel interfaces (valid/ready) for the accumulator.
// Depends on spa_pkg for field widths.
`default_nettype none
interface spa_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          operation;
   logic signed [spa_pkg::COEF_W-1:0]   term_coefficient;
   logic signed [spa_pkg::EXPO_W-1:0]   term_exponent;

   modport source (output valid, operation, term_coefficient, term_exponent, input ready);
   modport sink   (input valid, operation, term_coefficient, term_exponent, output ready);
endinterface

interface spa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [spa_pkg::COEF_W-1:0]   out_coefficient;
   logic signed [spa_pkg::EXPO_W-1:0]   out_exponent;
   logic [1:0]                          status;
   logic                                last_term;

   modport source (output valid, out_coefficient, out_exponent, status, last_term, input ready);
   modport sink   (input valid, out_coefficient, out_exponent, status, last_term, output ready);
endinterface
`default_nettype wire

@@ design/sparse_polynomial_accumulator.sv @@
// Top level: sorted sparse polynomial table with a sequencer around one compare/add unit.
// Depends on spa_pkg, spa_channels (spa_req_if, spa_rsp_if) and spa_term_table.
//
//   channel | dir | handshake   | payload
//   req     | in  | valid/ready | operation, term_coefficient, term_exponent
//   rsp     | out | valid/ready | out_coefficient, out_exponent, status, last_term
//
// Add: each slot walked is read, then compared/added, over every stored term
//   when a new term is inserted (shift ripples to the end).
// Read: each stored term is fetched, then examined and returned; clear completes in
//   the accepting cycle.
// The term memory's single read port paces the walk; req.ready is high only when idle.
// Reset (synchronous) empties the table; memory contents are not cleared.
// A stalled rsp channel holds the sequencer at its next response.
`default_nettype none
module sparse_polynomial_accumulator (
   input wire logic  clock,
   input wire logic  reset,
   spa_req_if.sink   req,
   spa_rsp_if.source rsp
);
   import spa_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_AFETCH = 3'd1;
   localparam logic [2:0] S_AEXAM  = 3'd2;
   localparam logic [2:0] S_RFETCH = 3'd3;
   localparam logic [2:0] S_REXAM  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             carrying_ff, carrying_in;
   term_type         carry_ff, carry_in;
   term_type         new_ff;

   logic             rsp_valid_ff;
   term_type         rsp_term_ff, rsp_term_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_load;
   logic             out_free;

   logic             wr_en, rd_en;
   term_type         wr_data, rd_data;
   logic [ADDR_W-1:0] addr;
   logic [COEF_W-1:0] sum;
   logic             full, at_end, last_read;

   spa_term_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign addr      = idx_ff[ADDR_W-1:0];
   assign full      = (count_ff == CNT_W'(MAX_TERMS));
   assign at_end    = (idx_ff == count_ff);
   assign last_read = ((idx_ff + CNT_W'(1)) == count_ff);
   assign sum       = sat_add(rd_data.coef, new_ff.coef);
   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      carrying_in   = carrying_ff;
      carry_in      = carry_ff;
      wr_en         = 1'b0;
      wr_data       = new_ff;
      rd_en         = 1'b0;
      rsp_load      = 1'b0;
      rsp_term_in   = new_ff;
      rsp_status_in = STAT_OK;
      rsp_last_in   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               idx_in      = '0;
               carrying_in = 1'b0;
               case (req.operation)
                  OP_ADD:   state_in = S_AFETCH;
                  OP_READ:  state_in = S_RFETCH;
                  OP_CLEAR: count_in = '0;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_AFETCH: begin
            if (at_end) begin
               // Walked past every term: append, finish a ripple, or drop.
               if (out_free) begin
                  rsp_load    = 1'b1;
                  state_in    = S_IDLE;
                  carrying_in = 1'b0;
                  if (carrying_ff) begin
                     wr_en    = 1'b1;
                     wr_data  = carry_ff;
                     count_in = count_ff + CNT_W'(1);
                  end else if (full) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_AEXAM;
            end
         end
         S_AEXAM: begin
            if (carrying_ff) begin
               // Ripple: store the displaced term, pick up the one here.
               wr_en    = 1'b1;
               wr_data  = carry_ff;
               carry_in = rd_data;
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_AFETCH;
            end else if ($signed(rd_data.expo) > $signed(new_ff.expo)) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_AFETCH;
            end else if (rd_data.expo == new_ff.expo) begin
               if (out_free) begin
                  wr_en            = 1'b1;
                  wr_data.coef     = sum;
                  rsp_load         = 1'b1;
                  rsp_term_in.coef = sum;
                  state_in         = S_IDLE;
               end
            end else if (full) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = STAT_FULL;
                  state_in      = S_IDLE;
               end
            end else begin
               wr_en       = 1'b1;
               carry_in    = rd_data;
               carrying_in = 1'b1;
               idx_in      = idx_ff + CNT_W'(1);
               state_in    = S_AFETCH;
            end
         end
         S_RFETCH: begin
            if (count_ff == '0) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_term_in   = '0;
                  rsp_status_in = STAT_EMPTY;
                  state_in      = S_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_REXAM;
            end
         end
         S_REXAM: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_term_in = rd_data;
               rsp_last_in = last_read;
               idx_in      = idx_ff + CNT_W'(1);
               state_in    = last_read ? S_IDLE : S_RFETCH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         carrying_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         count_ff    <= count_in;
         carrying_ff <= carrying_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      if (req.valid && req.ready) begin
         new_ff.coef <= req.term_coefficient;
         new_ff.expo <= req.term_exponent;
      end
      if (rsp_load) begin
         rsp_term_ff   <= rsp_term_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.out_coefficient = rsp_term_ff.coef;
   assign rsp.out_exponent    = rsp_term_ff.expo;
   assign rsp.status          = rsp_status_ff;
   assign rsp.last_term       = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TERMS))
      else $error("term count exceeds table size");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> idx_ff <= count_ff)
      else $error("walk index past term count");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_status_in == STAT_FULL |-> full)
      else $error("term dropped while table has room");

   a_ripple_room: assert property (@(posedge clock) disable iff (reset)
      carrying_ff |-> !full)
      else $error("insert ripple with full table");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> count_ff == '0 && !rsp_valid_ff)
      else $error("table not empty after reset");

endmodule
`default_nettype wire

@@ design/spa_term_table.sv @@
// Term storage: one write port, one read port with registered read data.
// Depends on spa_pkg for the term record and address width.
`default_nettype none
module spa_term_table (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [spa_pkg::ADDR_W-1:0] wr_addr,
   input  wire spa_pkg::term_type          wr_data,
   input  wire logic                       rd_en,
   input  wire logic [spa_pkg::ADDR_W-1:0] rd_addr,
   output spa_pkg::term_type               rd_data
);
   import spa_pkg::*;

   term_type mem [MAX_TERMS];
   term_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read so the sequencer can stall on it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
